>>> hdl/acpu_pkg.sv
// Shared types, field widths and code constants for the accumulator CPU core.
package acpu_pkg;

  localparam int WORD_W = 16;
  localparam int ADDR_W = 12;
  localparam int OPC_W  = 4;
  localparam int IMM_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [OPC_W-1:0]  opc_t;

  // Transaction operations on the request channel
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Result status codes; the halt cause register uses the first three
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_HALT    = 2'd1;
  localparam logic [1:0] STAT_BADOP   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  // Instruction opcodes
  localparam opc_t OPC_HALT  = 4'h0;
  localparam opc_t OPC_LOAD  = 4'h1;
  localparam opc_t OPC_STORE = 4'h2;
  localparam opc_t OPC_ADD   = 4'h3;
  localparam opc_t OPC_JUMP  = 4'h4;
  localparam opc_t OPC_JZ    = 4'h5;
  localparam opc_t OPC_JNZ   = 4'h6;
  localparam opc_t OPC_STI   = 4'h7;
  localparam opc_t OPC_SETC  = 4'h8;
  localparam opc_t OPC_SUB   = 4'h9;
  localparam opc_t OPC_NOP   = 4'hA;
  localparam opc_t OPC_ADDI  = 4'hB;
  localparam opc_t OPC_SUBI  = 4'hC;

endpackage

>>> hdl/acpu_req_if.sv
// Request channel: valid/ready handshake with the operation payload.
interface acpu_req_if
  import acpu_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  addr_t      mem_address;
  word_t      write_word;

  modport source (output valid, output op, output mem_address, output write_word,
                  input ready);
  modport sink   (input valid, input op, input mem_address, input write_word,
                  output ready);
endinterface

>>> hdl/acpu_rsp_if.sv
// Result channel: valid/ready handshake with the CPU state snapshot payload.
interface acpu_rsp_if
  import acpu_pkg::*;
();
  logic       valid;
  logic       ready;
  word_t      read_word;
  addr_t      program_counter;
  word_t      accumulator;
  word_t      instruction;
  logic [1:0] status;

  modport source (output valid, output read_word, output program_counter,
                  output accumulator, output instruction, output status,
                  input ready);
  modport sink   (input valid, input read_word, input program_counter,
                  input accumulator, input instruction, input status,
                  output ready);
endinterface

>>> hdl/accumulator_cpu_core.sv
// Accumulator CPU core: word memory, fetch/execute sequencer and result buffering.
// A write is done on acceptance, a read goes through the read state, a step through fetch
// and, for load, add, subtract and conditional jumps (a second memory read), execute; each
// result passes the result buffer, then the output register. A request is taken only in
// the idle state, so a read or step ends before the next; fetch and data access share the
// single memory read port in turn. Reset: synchronous; clears control and architectural
// registers, then zeroes the memory in a sweep, during which no request is accepted.
module accumulator_cpu_core
  import acpu_pkg::*;
#(
  parameter int MEM_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  acpu_req_if.sink    req,
  acpu_rsp_if.source  rsp
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [ADDR_W:0] MEM_LIMIT = (ADDR_W+1)'(MEM_DEPTH);
  localparam logic [AW-1:0]   CLR_LAST  = AW'(MEM_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  // Sequencer and architectural registers
  logic [1:0] state, state_next;
  addr_t      pc, pc_next;
  word_t      acc, acc_next;
  word_t      instr, instr_next;
  addr_t      cmp, cmp_next;
  logic [1:0] halt, halt_next;

  // Memory clear sweep
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Memory access
  logic    mem_we;
  addr_t   mem_wa;
  word_t   mem_wd;
  addr_t   rd_addr;
  logic    rd_ok;
  logic    ram_we;
  logic [AW-1:0] ram_wa;
  word_t   ram_wd;
  word_t   ram_q;
  word_t   rdata;

  // Result buffer and output register
  logic       res_load;
  word_t      res_rword_next;
  logic [1:0] res_status_next;
  logic       res_valid;
  word_t      res_rword;
  addr_t      res_pc;
  word_t      res_acc;
  word_t      res_instr;
  logic [1:0] res_status;
  logic       out_valid;
  logic       out_load;
  word_t      out_rword;
  addr_t      out_pc;
  word_t      out_acc;
  word_t      out_instr;
  logic [1:0] out_status;

  logic req_fire;
  opc_t f_opc, x_opc;
  addr_t f_opd, x_opd;

  assign out_load  = res_valid && (!out_valid || rsp.ready);
  assign req.ready = (state == ST_IDLE) && !clr_active && (!res_valid || out_load);
  assign req_fire  = req.valid && req.ready;

  // Mask reads beyond the memory to zero
  assign rdata = rd_ok ? ram_q : '0;
  assign f_opc = rdata[WORD_W-1 -: OPC_W];
  assign f_opd = rdata[ADDR_W-1:0];
  assign x_opc = instr[WORD_W-1 -: OPC_W];
  assign x_opd = instr[ADDR_W-1:0];

  // Next state, architectural updates and memory control
  always_comb begin
    state_next      = state;
    pc_next         = pc;
    acc_next        = acc;
    instr_next      = instr;
    cmp_next        = cmp;
    halt_next       = halt;
    res_load        = 1'b0;
    res_rword_next  = '0;
    res_status_next = STAT_OK;
    mem_we          = 1'b0;
    mem_wa          = req.mem_address;
    mem_wd          = req.write_word;
    rd_addr         = pc;

    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (req.op)
            OP_WRITE: begin
              mem_we   = 1'b1;
              res_load = 1'b1;
            end
            OP_READ: begin
              rd_addr    = req.mem_address;
              state_next = ST_READ;
            end
            OP_STEP: begin
              if (halt != STAT_OK) begin
                res_load        = 1'b1;
                res_status_next = STAT_IGNORED;
              end else begin
                rd_addr    = pc;
                state_next = ST_FETCH;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load       = 1'b1;
        res_rword_next = rdata;
        state_next     = ST_IDLE;
      end
      ST_FETCH: begin
        instr_next = rdata;
        pc_next    = pc + 1'b1;
        res_load   = 1'b1;
        state_next = ST_IDLE;
        unique case (f_opc)
          OPC_HALT: begin
            halt_next       = STAT_HALT;
            res_status_next = STAT_HALT;
          end
          OPC_LOAD, OPC_ADD, OPC_SUB: begin
            rd_addr    = f_opd;
            res_load   = 1'b0;
            state_next = ST_EXEC;
          end
          OPC_JZ, OPC_JNZ: begin
            rd_addr    = cmp;
            res_load   = 1'b0;
            state_next = ST_EXEC;
          end
          OPC_STORE: begin
            mem_we = 1'b1;
            mem_wa = f_opd;
            mem_wd = acc;
          end
          OPC_STI: begin
            mem_we = 1'b1;
            mem_wa = {{(ADDR_W-IMM_W){1'b0}}, f_opd[IMM_W-1:0]};
            mem_wd = {{(WORD_W-IMM_W){1'b0}}, f_opd[2*IMM_W-1:IMM_W]};
          end
          OPC_JUMP: pc_next  = f_opd;
          OPC_SETC: cmp_next = f_opd;
          OPC_NOP: ;
          OPC_ADDI: acc_next = acc + {{(WORD_W-ADDR_W){1'b0}}, f_opd};
          OPC_SUBI: acc_next = acc - {{(WORD_W-ADDR_W){1'b0}}, f_opd};
          default: begin
            halt_next       = STAT_BADOP;
            res_status_next = STAT_BADOP;
          end
        endcase
      end
      ST_EXEC: begin
        res_load   = 1'b1;
        state_next = ST_IDLE;
        unique case (x_opc)
          OPC_LOAD: acc_next = rdata;
          OPC_ADD:  acc_next = acc + rdata;
          OPC_SUB:  acc_next = acc - rdata;
          OPC_JZ:   if (rdata == '0) pc_next = x_opd;
          OPC_JNZ:  if (rdata != '0) pc_next = x_opd;
          default: ;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port: clear sweep owns the write port after reset; drop out-of-range writes
  assign ram_we = clr_active || (mem_we && ({1'b0, mem_wa} < MEM_LIMIT));
  assign ram_wa = clr_active ? clr_addr : mem_wa[AW-1:0];
  assign ram_wd = clr_active ? '0 : mem_wd;

  acpu_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_q)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= '0;
      acc        <= '0;
      instr      <= '0;
      cmp        <= '0;
      halt       <= STAT_OK;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      res_valid  <= 1'b0;
      out_valid  <= 1'b0;
      rd_ok      <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      acc   <= acc_next;
      instr <= instr_next;
      cmp   <= cmp_next;
      halt  <= halt_next;
      rd_ok <= ({1'b0, rd_addr} < MEM_LIMIT);
      // Advance the clear sweep
      if (clr_active) begin
        if (clr_addr == CLR_LAST) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
      // Result buffer fills on completion, drains into the output register
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_load) begin
        res_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_rword  <= res_rword_next;
      res_pc     <= pc_next;
      res_acc    <= acc_next;
      res_instr  <= instr_next;
      res_status <= res_status_next;
    end
    if (out_load) begin
      out_rword  <= res_rword;
      out_pc     <= res_pc;
      out_acc    <= res_acc;
      out_instr  <= res_instr;
      out_status <= res_status;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.read_word       = out_rword;
  assign rsp.program_counter = out_pc;
  assign rsp.accumulator     = out_acc;
  assign rsp.instruction     = out_instr;
  assign rsp.status          = out_status;

endmodule

>>> hdl/acpu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module acpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first-come, read registered (old data on same-edge collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/acpu_checker.sv
// Port-level assertions for the accumulator CPU core, bound to the core module.
module acpu_checker
  import acpu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input word_t      rsp_read_word,
  input addr_t      rsp_program_counter,
  input word_t      rsp_accumulator,
  input word_t      rsp_instruction,
  input logic [1:0] rsp_status
);

  // Hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_word)
      && $stable(rsp_program_counter) && $stable(rsp_accumulator)
      && $stable(rsp_instruction) && $stable(rsp_status))
    else $error("result changed while stalled");

  // No result right after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Only a plain read returns memory data, so nonzero read data comes only with OK status
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_read_word != '0 |-> rsp_status == STAT_OK)
    else $error("read data with non-ok status");

  // Halt status matches the fetched opcode
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_HALT
      |-> rsp_instruction[WORD_W-1 -: OPC_W] == OPC_HALT)
    else $error("halt status without halt opcode");

  // Unknown-opcode status only for opcodes above the defined set
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_BADOP
      |-> rsp_instruction[WORD_W-1 -: OPC_W] > OPC_SUBI)
    else $error("bad-opcode status on a defined opcode");

endmodule

bind accumulator_cpu_core acpu_checker u_acpu_checker (
  .clk                 (clk),
  .rst                 (rst),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_read_word       (rsp.read_word),
  .rsp_program_counter (rsp.program_counter),
  .rsp_accumulator     (rsp.accumulator),
  .rsp_instruction     (rsp.instruction),
  .rsp_status          (rsp.status)
);

>>> bench/accumulator_cpu_core_checker.sv
// Checker for the accumulator CPU core: predicts each result and compares it.
`timescale 1ns / 1ps

module accumulator_cpu_core_checker
  import acpu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  acpu_req_if  req,
  acpu_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  localparam int MEM_WORDS = 1 << ADDR_W;

  typedef struct packed {
    word_t      read_word;
    addr_t      program_counter;
    word_t      accumulator;
    word_t      instruction;
    logic [1:0] status;
  } cpu_snapshot_t;

  // Shadow CPU state
  word_t      shadow_mem [MEM_WORDS];
  addr_t      pc_q;
  word_t      acc_q;
  word_t      ir_q;
  addr_t      cmp_q;
  logic [1:0] halt_q;

  cpu_snapshot_t expected_snapshots[$];
  int fail_count = 0;
  int pending_count = 0;

  assign errors  = fail_count;
  assign pending = pending_count;

  // Apply one transaction to the shadow state and return the snapshot it yields
  function automatic cpu_snapshot_t execute_transaction(logic [1:0] op, addr_t a, word_t w);
    cpu_snapshot_t snap;
    opc_t          opc;
    addr_t         opd;
    snap = '0;
    case (op)
      OP_WRITE: shadow_mem[a] = w;
      OP_READ:  snap.read_word = shadow_mem[a];
      OP_STEP: begin
        if (halt_q != STAT_OK) begin
          snap.status = STAT_IGNORED;
        end else begin
          // fetch and advance, then execute
          ir_q = shadow_mem[pc_q];
          pc_q = pc_q + 1'b1;
          opc  = ir_q[WORD_W-1 -: OPC_W];
          opd  = ir_q[ADDR_W-1:0];
          case (opc)
            OPC_HALT: begin
              halt_q      = STAT_HALT;
              snap.status = STAT_HALT;
            end
            OPC_LOAD:  acc_q = shadow_mem[opd];
            OPC_STORE: shadow_mem[opd] = acc_q;
            OPC_ADD:   acc_q = acc_q + shadow_mem[opd];
            OPC_JUMP:  pc_q = opd;
            OPC_JZ:    if (shadow_mem[cmp_q] == '0) pc_q = opd;
            OPC_JNZ:   if (shadow_mem[cmp_q] != '0) pc_q = opd;
            OPC_STI:   shadow_mem[addr_t'(opd[IMM_W-1:0])] = word_t'(opd[2*IMM_W-1:IMM_W]);
            OPC_SETC:  cmp_q = opd;
            OPC_SUB:   acc_q = acc_q - shadow_mem[opd];
            OPC_NOP:   ;
            OPC_ADDI:  acc_q = acc_q + word_t'(opd);
            OPC_SUBI:  acc_q = acc_q - word_t'(opd);
            default: begin
              halt_q      = STAT_BADOP;
              snap.status = STAT_BADOP;
            end
          endcase
        end
      end
      default: ;
    endcase
    snap.program_counter = pc_q;
    snap.accumulator     = acc_q;
    snap.instruction     = ir_q;
    return snap;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] exp_val,
                                      logic [WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Track accepted requests and compare accepted results in order
  always @(posedge clk) begin
    cpu_snapshot_t exp_snap;
    if (rst) begin
      foreach (shadow_mem[i]) shadow_mem[i] = '0;
      pc_q   = '0;
      acc_q  = '0;
      ir_q   = '0;
      cmp_q  = '0;
      halt_q = STAT_OK;
      expected_snapshots.delete();
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        expected_snapshots.push_back(execute_transaction(req.op, req.mem_address,
                                                         req.write_word));
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (expected_snapshots.size() == 0) begin
          $error("result transaction arrived with no request outstanding");
          fail_count++;
        end else begin
          exp_snap = expected_snapshots.pop_front();
          check_field("read_word", exp_snap.read_word, rsp.read_word);
          check_field("program_counter", WORD_W'(exp_snap.program_counter),
                      WORD_W'(rsp.program_counter));
          check_field("accumulator", exp_snap.accumulator, rsp.accumulator);
          check_field("instruction", exp_snap.instruction, rsp.instruction);
          check_field("status", WORD_W'(exp_snap.status), WORD_W'(rsp.status));
        end
      end
    end
    pending_count = expected_snapshots.size();
  end

endmodule

>>> bench/accumulator_cpu_core_tb.sv
// Top of the accumulator CPU core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module accumulator_cpu_core_tb;
  import acpu_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam addr_t      CODE_BASE  = 12'h800;
  localparam int         CODE_SLOTS = 64;
  localparam addr_t      DATA_BASE  = 12'h900;
  localparam int         DATA_SPAN  = 32;
  localparam int         RANDOM_ITEMS = 480;

  logic clk = 1'b0;
  logic rst;
  bit   no_idle;
  int   sent_count;
  int   fail_count;
  int   pending_count;

  acpu_req_if req_ch ();
  acpu_rsp_if rsp_ch ();

  accumulator_cpu_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  accumulator_cpu_core_checker result_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none during steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Data operand: low words, the data window, or anywhere
  function automatic addr_t operand_address();
    case ($urandom_range(0, 2))
      0:       return addr_t'($urandom_range(0, 63));
      1:       return DATA_BASE + addr_t'($urandom_range(0, DATA_SPAN - 1));
      default: return addr_t'($urandom);
    endcase
  endfunction

  function automatic addr_t off_code_address();
    addr_t a;
    do a = operand_address();
    while (a >= CODE_BASE && a < CODE_BASE + CODE_SLOTS);
    return a;
  endfunction

  // Instruction that keeps the program counter inside the code window
  function automatic word_t code_word(int slot);
    opc_t  opc;
    addr_t opd;
    if (slot == CODE_SLOTS - 1) opc = OPC_JUMP;
    else opc = opc_t'($urandom_range(OPC_LOAD, OPC_SUBI));
    case (opc)
      OPC_LOAD, OPC_ADD, OPC_SUB, OPC_SETC: opd = operand_address();
      OPC_STORE:                            opd = off_code_address();
      OPC_JUMP, OPC_JZ, OPC_JNZ: opd = CODE_BASE + addr_t'($urandom_range(0, CODE_SLOTS - 1));
      default:                              opd = addr_t'($urandom);
    endcase
    return {opc, opd};
  endfunction

  // Halt opcode or one of the unknown opcodes above the last defined one
  function automatic word_t halt_word();
    int   r;
    opc_t opc;
    r = $urandom_range(0, 3);
    opc = (r == 0) ? OPC_HALT : OPC_SUBI + opc_t'(r);
    return {opc, addr_t'($urandom)};
  endfunction

  // Present one request transaction and hold it until accepted
  task automatic send(logic [1:0] op, addr_t a, word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.mem_address <= a;
    req_ch.write_word  <= w;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    if (op != OP_UNUSED) sent_count++;
  endtask

  // Background traffic: reads, data writes and the unused operation
  task automatic send_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) send(OP_READ, addr_t'($urandom), word_t'($urandom));
    else if (r < 4) send(OP_READ, operand_address(), word_t'($urandom));
    else if (r < 9) send(OP_WRITE, off_code_address(), word_t'($urandom));
    else send(OP_UNUSED, addr_t'($urandom), word_t'($urandom));
  endtask

  // Result side: random stalls of varying length
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (no_idle) stall = 0;
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        rsp_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  initial begin
    int    n;
    int    r;
    int    slot;
    addr_t a;
    word_t w;
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_WRITE;
    req_ch.mem_address <= '0;
    req_ch.write_word  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme data word, then a short program touching every opcode but halt
    send(OP_WRITE, 12'hFFF, 16'hFFFF);
    send(OP_READ, 12'hFFF, 16'h0000);
    send(OP_WRITE, 12'h000, {OPC_LOAD, 12'hFFF});
    send(OP_WRITE, 12'h001, {OPC_ADDI, 12'hFFF});
    send(OP_WRITE, 12'h002, {OPC_SUB, 12'h000});
    send(OP_WRITE, 12'h003, {OPC_ADD, 12'hFFF});
    send(OP_WRITE, 12'h004, {OPC_SUBI, 12'hFFF});
    send(OP_WRITE, 12'h005, {OPC_STORE, 12'h0FE});
    send(OP_WRITE, 12'h006, {OPC_STI, 12'hFFF});
    send(OP_WRITE, 12'h007, {OPC_SETC, 12'h03F});
    // compare word is nonzero: the first branch falls through, the second jumps
    send(OP_WRITE, 12'h008, {OPC_JZ, 12'h00A});
    send(OP_WRITE, 12'h009, {OPC_JNZ, 12'h00B});
    send(OP_WRITE, 12'h00B, {OPC_NOP, 12'h000});
    send(OP_WRITE, 12'h00C, {OPC_JUMP, CODE_BASE});
    repeat (12) send(OP_STEP, addr_t'($urandom), word_t'($urandom));

    // Random: load a program into the code window, then run it amid other traffic
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < CODE_SLOTS; s++) begin
        send(OP_WRITE, CODE_BASE + addr_t'(s), code_word(s));
        if ($urandom_range(0, 7) == 0) send_noise();
      end
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 90);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send(OP_STEP, addr_t'($urandom), word_t'($urandom));
        end else if (r < 92) begin
          send_noise();
        end else begin
          slot = $urandom_range(0, CODE_SLOTS - 1);
          send(OP_WRITE, CODE_BASE + addr_t'(slot), code_word(slot));
        end
      end
    end

    // Finale: fill the code window with halting words, then poke the halted CPU
    no_idle = 1'b0;
    for (int s = 0; s < CODE_SLOTS; s++) begin
      send(OP_WRITE, CODE_BASE + addr_t'(s), halt_word());
    end
    repeat ($urandom_range(3, 6)) send(OP_STEP, addr_t'($urandom), word_t'($urandom));
    a = off_code_address();
    w = word_t'($urandom);
    send(OP_WRITE, a, w);
    send(OP_READ, a, word_t'($urandom));
    send(OP_UNUSED, addr_t'($urandom), word_t'($urandom));
    send(OP_STEP, addr_t'($urandom), word_t'($urandom));
    req_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for stray ones
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
hdl/acpu_pkg.sv
hdl/acpu_req_if.sv
hdl/acpu_rsp_if.sv
hdl/acpu_ram.sv
hdl/accumulator_cpu_core.sv
hdl/acpu_checker.sv
bench/accumulator_cpu_core_checker.sv
bench/accumulator_cpu_core_tb.sv
